// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the profiler rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pplp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplp_pkg
// types and codes shared by the per-phase latency profiler modules
// ----------------------------------------------------------------------------
package pplp_pkg;

    localparam int DIV_STEPS = 32;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OFF     = 2'd1;
    localparam logic [1:0] ST_BADPH   = 2'd2;
    localparam logic [1:0] ST_NOSTART = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  phase;
        logic [31:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] elapsed;
        logic [31:0] sample_count;
        logic [31:0] peak;
        logic [31:0] average;
    } t_out_word;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] peak;
        logic [31:0] sum;
    } t_stats;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_stats;
        logic wr_start;
        logic set_act;
        logic clr_act;
    } t_tbl_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ELAPSE,
        S_UPDATE,
        S_DIV
    } t_seq_state;

endpackage

// ===== design/pplp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplp_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pplp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import pplp_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_done;
    logic [31:0]   r_rem;
    logic [31:0]   r_quo;
    logic [31:0]   r_den;
    logic [32:0]   rem_sh;
    logic [32:0]   diff;
    logic          ge;

    // shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
        n_cnt  = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= n_cnt;
                if (n_cnt == '0) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/pplp_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplp_table
// per-phase statistics and start-time memories with valid and active flags
// ----------------------------------------------------------------------------
module pplp_table #(
    parameter int PHASES = 16,
    parameter int IW     = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pplp_pkg::t_tbl_ctrl i_ctrl,
    input  logic [IW-1:0]      i_idx,
    input  pplp_pkg::t_stats   i_stats,
    input  logic [31:0]        i_start_time,
    output pplp_pkg::t_stats   o_stats,
    output logic [31:0]        o_start_time,
    output logic               o_active
);
    import pplp_pkg::*;

    t_stats            r_stat_mem [PHASES];
    logic [31:0]       r_time_mem [PHASES];
    logic [PHASES-1:0] r_valid;
    logic [PHASES-1:0] r_active;
    t_stats            r_rd_stats;
    logic [31:0]       r_rd_time;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_stats) begin
            r_stat_mem[i_idx] <= i_stats;
        end
        if (i_ctrl.wr_start) begin
            r_time_mem[i_idx] <= i_start_time;
        end
        if (i_ctrl.rd_en) begin
            r_rd_stats <= r_stat_mem[i_idx];
            r_rd_time  <= r_time_mem[i_idx];
            r_rd_valid <= r_valid[i_idx];
        end
    end

    // a clear drops every valid and active flag at once, stale statistics then read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
        end else if (i_ctrl.clear) begin
            r_valid  <= '0;
            r_active <= '0;
        end else begin
            if (i_ctrl.wr_stats) begin
                r_valid[i_idx] <= 1'b1;
            end
            if (i_ctrl.set_act) begin
                r_active[i_idx] <= 1'b1;
            end else if (i_ctrl.clr_act) begin
                r_active[i_idx] <= 1'b0;
            end
        end
    end

    assign o_stats      = r_rd_valid ? r_rd_stats : '0;
    assign o_start_time = r_rd_time;
    assign o_active     = r_active[i_idx];

endmodule

// ===== design/per_phase_latency_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_phase_latency_profiler_core
// per-phase start/stop latency statistics with iterative average divide
// ----------------------------------------------------------------------------
// each word steps through the read, elapse, update and divide states, and the
// result strobe is registered once the single 32-step divider finishes
// busy is high from acceptance until the strobe cycle, which may take a new word
// results are strobed for one cycle and cannot be held off by the receiver
// synchronous active-low reset clears the table flags, enable and sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_phase_latency_profiler_core #(
    parameter int PHASES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pplp_pkg::t_in_word  i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output logic                o_strobe,
    output pplp_pkg::t_out_word o_result
);
    import pplp_pkg::*;

    localparam int         IW     = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam logic [8:0] PH_LIM = 9'(PHASES);

    t_seq_state  r_state;
    t_seq_state  n_state;
    t_in_word    r_item;
    logic        r_ph_ok;
    logic        r_enable;
    logic [31:0] r_elapsed;
    logic [1:0]  r_status;
    logic [31:0] r_el_out;
    t_stats      r_res;
    logic        r_strobe;
    t_out_word   r_result;

    logic [1:0]  n_status;
    logic [31:0] n_el_out;
    t_stats      n_res;
    logic        dec_clear;
    logic        dec_wr_stats;
    logic        dec_wr_start;
    logic        dec_set_act;
    logic        dec_clr_act;
    logic        cfg_clear;
    logic        accept;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;
    t_tbl_ctrl   tbl_ctrl;
    t_stats      tbl_stats;
    logic [31:0] tbl_time;
    logic        tbl_active;
    logic [IW-1:0] idx;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign idx       = r_item.phase[IW-1:0];
    assign cfg_clear = i_cfg_we && i_cfg_wdata && !r_enable;

    // event decode on the word held during the update step
    always_comb begin
        n_status     = ST_OK;
        n_el_out     = '0;
        n_res        = tbl_stats;
        dec_clear    = 1'b0;
        dec_wr_stats = 1'b0;
        dec_wr_start = 1'b0;
        dec_set_act  = 1'b0;
        dec_clr_act  = 1'b0;
        case (r_item.kind)
            KIND_CLEAR: begin
                dec_clear = 1'b1;
                n_res     = '0;
            end
            KIND_START, KIND_STOP: begin
                if (!r_enable) begin
                    n_status = ST_OFF;
                    if (!r_ph_ok) begin
                        n_res = '0;
                    end
                end else if (!r_ph_ok) begin
                    n_status = ST_BADPH;
                    n_res    = '0;
                end else if (r_item.kind == KIND_START) begin
                    dec_wr_start = 1'b1;
                    dec_set_act  = 1'b1;
                end else if (!tbl_active) begin
                    n_status = ST_NOSTART;
                end else begin
                    n_el_out     = r_elapsed;
                    n_res.count  = tbl_stats.count + 32'd1;
                    n_res.sum    = tbl_stats.sum + r_elapsed;
                    n_res.peak   = (r_elapsed > tbl_stats.peak) ? r_elapsed
                                                                : tbl_stats.peak;
                    dec_wr_stats = 1'b1;
                    dec_clr_act  = 1'b1;
                end
            end
            default: begin
                if (!r_ph_ok) begin
                    n_status = ST_BADPH;
                    n_res    = '0;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_READ;
            S_READ:   n_state = S_ELAPSE;
            S_ELAPSE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        tbl_ctrl  = '0;
        div_start = 1'b0;
        case (r_state)
            S_READ: begin
                tbl_ctrl.rd_en = 1'b1;
            end
            S_UPDATE: begin
                tbl_ctrl.clear    = dec_clear;
                tbl_ctrl.wr_stats = dec_wr_stats;
                tbl_ctrl.wr_start = dec_wr_start;
                tbl_ctrl.set_act  = dec_set_act;
                tbl_ctrl.clr_act  = dec_clr_act;
                div_start         = 1'b1;
            end
            default: begin
                tbl_ctrl = '0;
            end
        endcase
        if (cfg_clear) begin
            tbl_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_enable <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= div_done;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_ph_ok <= {1'b0, i_item.phase} < PH_LIM;
        end
        if (r_state == S_ELAPSE) begin
            r_elapsed <= r_item.timestamp - tbl_time;
        end
        if (r_state == S_UPDATE) begin
            r_status <= n_status;
            r_el_out <= n_el_out;
            r_res    <= n_res;
        end
        if (div_done) begin
            r_result.status       <= r_status;
            r_result.elapsed      <= r_el_out;
            r_result.sample_count <= r_res.count;
            r_result.peak         <= r_res.peak;
            r_result.average      <= (r_res.count == '0) ? '0 : div_quo;
        end
    end

    pplp_table #(
        .PHASES (PHASES),
        .IW     (IW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tbl_ctrl),
        .i_idx        (idx),
        .i_stats      (n_res),
        .i_start_time (r_item.timestamp),
        .o_stats      (tbl_stats),
        .o_start_time (tbl_time),
        .o_active     (tbl_active)
    );

    pplp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_res.sum),
        .i_divisor  (n_res.count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ASSERT_IMPLIES(a_strobe_after_div, i_clk, i_rst_n, o_strobe, $past(r_state == S_DIV))
    `ASSERT_IMPLIES(a_strobe_not_busy, i_clk, i_rst_n, o_strobe, !busy)
    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the per-phase latency profiler core: a short table
// of start/stop/clear/query words, then random start/stop pairs with noise,
// under several monitor enable settings; every result word is compared with a
// literal expected word or a behavioural model of the statistics table
// ----------------------------------------------------------------------------
module tb;
    import pplp_pkg::*;

    localparam int PHASES          = 16;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RAND_BLOCKS     = 8;
    localparam int WORDS_PER_BLOCK = 50;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op   op;
        logic      en;
        t_in_word  word;
        logic      lit;
        t_out_word res;
    } t_plan_row;

    localparam t_in_word  NO_WORD  = '0;
    localparam t_out_word OK0      = '{ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
    localparam t_out_word OFF0     = '{ST_OFF, 32'd0, 32'd0, 32'd0, 32'd0};
    localparam t_out_word BADPH0   = '{ST_BADPH, 32'd0, 32'd0, 32'd0, 32'd0};
    localparam t_out_word NOSTART0 = '{ST_NOSTART, 32'd0, 32'd0, 32'd0, 32'd0};

    localparam int PLAN_ROWS = 28;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // monitor still off after reset
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd0, 32'd0}, 1'b1, OFF0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd255, 32'd0}, 1'b1, OFF0},
        '{ROW_WORD, 1'b0, '{KIND_QUERY, 8'd3, 32'd0}, 1'b1, OK0},
        '{ROW_WORD, 1'b0, '{KIND_QUERY, 8'd255, 32'd0}, 1'b1, BADPH0},
        '{ROW_WORD, 1'b0, '{KIND_CLEAR, 8'd200, 32'hFFFF_FFFF}, 1'b1, OK0},
        '{ROW_CFG, 1'b1, NO_WORD, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd0, 32'd0}, 1'b1, NOSTART0},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd16, 32'd0}, 1'b1, BADPH0},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd0, 32'd0}, 1'b1, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd0, 32'hFFFF_FFFF}, 1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        // elapsed wraps through zero
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd15, 32'hFFFF_FFF0}, 1'b1, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd15, 32'h10}, 1'b1,
          '{ST_OK, 32'h20, 32'd1, 32'h20, 32'h20}},
        // second start overwrites the first
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd15, 32'd5}, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd15, 32'd100}, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd15, 32'd103}, 1'b1,
          '{ST_OK, 32'd3, 32'd2, 32'h20, 32'd17}},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd0, 32'd10}, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd0, 32'd10}, 1'b1,
          '{ST_OK, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF}},
        // sum wraps to 1
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd0, 32'd0}, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd0, 32'd2}, 1'b1,
          '{ST_OK, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'd0}},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd7, 32'd1}, 1'b0, OK0},
        '{ROW_CFG, 1'b0, NO_WORD, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd7, 32'd9}, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_QUERY, 8'd15, 32'd0}, 1'b0, OK0},
        // re-enabling wipes the table, active marks included
        '{ROW_CFG, 1'b1, NO_WORD, 1'b0, OK0},
        '{ROW_WORD, 1'b0, '{KIND_STOP, 8'd7, 32'd9}, 1'b1, NOSTART0},
        '{ROW_WORD, 1'b0, '{KIND_QUERY, 8'd15, 32'd0}, 1'b1, OK0},
        '{ROW_WORD, 1'b0, '{KIND_START, 8'd128, 32'd0}, 1'b1, BADPH0},
        '{ROW_WORD, 1'b0, '{KIND_CLEAR, 8'd15, 32'd0}, 1'b1, OK0}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    logic      busy;
    t_in_word  i_item      = '0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      o_strobe;
    t_out_word o_result;

    // model of the statistics table
    t_stats      ph_stats  [PHASES];
    logic [31:0] ph_start  [PHASES];
    logic        ph_active [PHASES];
    logic        mon_enable = 1'b0;

    t_out_word expected_results [$];
    int        fail_count  = 0;
    int        quiet_cycles = 0;

    per_phase_latency_profiler_core #(
        .PHASES(PHASES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void wipe_table();
        for (int p = 0; p < PHASES; p++) begin
            ph_stats[p]  = '0;
            ph_start[p]  = '0;
            ph_active[p] = 1'b0;
        end
    endfunction

    function automatic t_out_word profile_event(input t_in_word w);
        t_out_word r;
        logic      in_range;
        r        = '0;
        in_range = (w.phase < PHASES);
        if (w.kind == KIND_CLEAR) begin
            wipe_table();
        end else if ((w.kind == KIND_START || w.kind == KIND_STOP) && !mon_enable) begin
            r.status = ST_OFF;
        end else if (!in_range) begin
            r.status = ST_BADPH;
        end else if (w.kind == KIND_START) begin
            ph_start[w.phase]  = w.timestamp;
            ph_active[w.phase] = 1'b1;
        end else if (w.kind == KIND_STOP) begin
            if (!ph_active[w.phase]) begin
                r.status = ST_NOSTART;
            end else begin
                r.elapsed                = w.timestamp - ph_start[w.phase];
                ph_stats[w.phase].count += 32'd1;
                ph_stats[w.phase].sum   += r.elapsed;
                if (r.elapsed > ph_stats[w.phase].peak) begin
                    ph_stats[w.phase].peak = r.elapsed;
                end
                ph_active[w.phase] = 1'b0;
            end
        end
        if (in_range && w.kind != KIND_CLEAR) begin
            r.sample_count = ph_stats[w.phase].count;
            r.peak         = ph_stats[w.phase].peak;
            r.average      = (ph_stats[w.phase].count == 0) ? 32'd0 :
                             ph_stats[w.phase].sum / ph_stats[w.phase].count;
        end
        return r;
    endfunction

    // start stays high until the word is taken
    task automatic issue_event(input t_in_word w, input logic use_lit,
                               input t_out_word lit_res);
        t_out_word predicted;
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = profile_event(w);
        expected_results.push_back(use_lit ? lit_res : predicted);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_monitor_enable(input logic en);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (en && !mon_enable) begin
            wipe_table();
        end
        mon_enable = en;
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %p",
                         $time, o_result);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("elapsed", want.elapsed, o_result.elapsed);
                check_field("sample_count", want.sample_count, o_result.sample_count);
                check_field("peak", want.peak, o_result.peak);
                check_field("average", want.average, o_result.average);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_in_word    w;
        int          roll;
        int          gap_pct;
        logic [31:0] span;
        wipe_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].op == ROW_CFG) begin
                wait_idle();
                set_monitor_enable(PLAN[r].en);
            end else begin
                issue_event(PLAN[r].word, PLAN[r].lit, PLAN[r].res);
            end
        end

        // enable sequence 1,0,1,1,0,1,1,1 covers 1->1, 1->0 and 0->1 writes
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            wait_idle();
            set_monitor_enable(!(b == 1 || b == 4));
            gap_pct = (b == RAND_BLOCKS - 1 || $urandom_range(0, 2) == 0) ? 0 : 30;
            for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                roll        = $urandom_range(0, 99);
                w.timestamp = $urandom;
                w.phase     = 8'($urandom_range(0, PHASES - 1));
                if (roll < 70) begin
                    // well-formed start/stop pairs on the tracked phases
                    if (ph_active[w.phase]) begin
                        case ($urandom_range(0, 3))
                            0:       span = $urandom_range(0, 15);
                            1:       span = $urandom_range(0, 2000);
                            2:       span = $urandom;
                            default: span = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        endcase
                        w.kind      = KIND_STOP;
                        w.timestamp = ph_start[w.phase] + span;
                    end else begin
                        w.kind = KIND_START;
                    end
                end else if (roll < 82) begin
                    w.kind = KIND_QUERY;
                    if ($urandom_range(0, 1)) begin
                        w.phase = 8'($urandom_range(0, 255));
                    end
                end else if (roll < 85) begin
                    w.kind = KIND_CLEAR;
                end else begin
                    w.kind  = 2'($urandom_range(0, 3));
                    w.phase = 8'($urandom_range(0, 255));
                end
                issue_event(w, 1'b0, OK0);
                if ($urandom_range(0, 99) < gap_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
